// ===== rtl/mfbr_pkg.sv =====
package mfbr_pkg;

  // Request kinds carried on req_type.
  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_START = 2'd1,
    REQ_SKIP  = 2'd2,
    REQ_READ  = 2'd3
  } req_e;

  // Widest field a read returns, and the width of its bit counter.
  localparam int unsigned READ_MAX = 32;
  localparam int unsigned LEFT_W   = 6;

  // Operand width of the serial modular reducer. It covers a 12-bit address and
  // the byte count of a skip, (65535 + 7) >> 3.
  localparam int unsigned RED_W = 14;

  // Masks that keep the low n bits of a byte.
  localparam logic [7:0] LOW_MASK [0:8] = '{
    8'h00, 8'h01, 8'h03, 8'h07, 8'h0f, 8'h1f, 8'h3f, 8'h7f, 8'hff
  };

endpackage

// ===== rtl/mfbr_modred.sv =====
module mfbr_modred #(
  parameter int unsigned MOD = 4096,
  parameter int unsigned AW  = 12
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [mfbr_pkg::RED_W-1:0] operand_i,
  output logic                       done_o,
  output logic [AW-1:0]              result_o
);

  localparam int unsigned CW = $clog2(mfbr_pkg::RED_W + 1);
  localparam logic [AW:0] ModW = (AW+1)'(MOD);

  logic                       busy_q;
  logic [CW-1:0]              cnt_q;
  logic [mfbr_pkg::RED_W-1:0] shift_q;
  logic [AW-1:0]              rem_q;
  logic [AW:0]                trial;
  logic [AW:0]                rem_d;

  // One operand bit per cycle, most significant first: rem = (2 * rem + bit) mod MOD.
  // Since rem < MOD, a single conditional subtract keeps it reduced.
  always_comb begin
    trial = {rem_q, shift_q[mfbr_pkg::RED_W-1]};
    rem_d = (trial >= ModW) ? (trial - ModW) : trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(mfbr_pkg::RED_W);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      shift_q <= operand_i;
      rem_q   <= '0;
    end else if (busy_q && (cnt_q != '0)) begin
      shift_q <= shift_q << 1;
      rem_q   <= rem_d[AW-1:0];
    end
  end

  assign done_o   = busy_q && (cnt_q == '0);
  assign result_o = rem_q;

endmodule

// ===== rtl/mfbr_mem.sv =====
module mfbr_mem #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/msb_first_bit_reader.sv =====
// Channel  Dir  Handshake                  Payload
// request  in   in_valid_i / in_ready_o    req_type_i, address_i, write_data_i, bit_count_i
// result   out  out_valid_o / out_ready_i  read_value_o (reads only)
//
// One request is worked on at a time. A read touches B bytes of memory (1 to 5), which
// the byte memory delivers one byte per cycle from a registered read port. A read with
// no stream base returns zero without fetching. A write, start or skip waits on the
// bit-serial modulo-MEM_BYTES reducer.
// Reset clears the stream base and position and the output register; the byte memory has no clearing pass.
// A finished result waits in the output register while the next request is accepted.
module msb_first_bit_reader #(
  parameter int unsigned MEM_BYTES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [11:0] address_i,
  input  logic [7:0]  write_data_i,
  input  logic [15:0] bit_count_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] read_value_o
);

  localparam int unsigned AW = $clog2(MEM_BYTES);
  localparam logic [AW:0]   ModW  = (AW+1)'(MEM_BYTES);
  localparam logic [AW-1:0] LastW = AW'(MEM_BYTES - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RED,
    S_FETCH,
    S_READ,
    S_PUSH
  } state_e;

  state_e                      state_q;
  mfbr_pkg::req_e              op_q;
  logic [7:0]                  wdata_q;
  logic                        base_zero_q;
  logic [AW-1:0]               base_mod_q;
  logic [AW-1:0]               ptr_q;
  logic [AW-1:0]               fptr_q;
  logic [2:0]                  bo_q;
  logic [mfbr_pkg::LEFT_W-1:0] left_q;
  logic [31:0]                 acc_q;
  logic                        out_valid_q;
  logic [31:0]                 out_q;

  logic                        accept;
  mfbr_pkg::req_e              req;
  logic [16:0]                 skip_total;
  logic [mfbr_pkg::RED_W-1:0]  red_operand;
  logic                        red_done;
  logic [AW-1:0]               red_result;
  logic [mfbr_pkg::LEFT_W-1:0] want;
  logic [AW:0]                 ptr_sum;
  logic [AW-1:0]               ptr_add;
  logic [AW-1:0]               ptr_inc;
  logic [AW-1:0]               fptr_inc;
  logic [AW-1:0]               swz;
  logic [AW:0]                 swz_red;
  logic [AW:0]                 faddr_sum;
  logic [AW-1:0]               faddr;
  logic                        mem_we;
  logic [7:0]                  rdata;
  logic [3:0]                  avail;
  logic [3:0]                  take;
  logic [2:0]                  drop;
  logic [7:0]                  field;
  logic [31:0]                 acc_d;
  logic [3:0]                  bo_sum;
  logic [mfbr_pkg::LEFT_W-1:0] left_d;

  assign accept = in_valid_i && in_ready_o;
  assign req    = mfbr_pkg::req_e'(req_type_i);

  assign skip_total  = {1'b0, bit_count_i} + 17'(bo_q);
  assign red_operand = (req == mfbr_pkg::REQ_SKIP) ? skip_total[16:3]
                                                   : mfbr_pkg::RED_W'(address_i);

  always_comb begin
    if (bit_count_i == '0) begin
      want = mfbr_pkg::LEFT_W'(1);
    end else if (bit_count_i > 16'(mfbr_pkg::READ_MAX)) begin
      want = mfbr_pkg::LEFT_W'(mfbr_pkg::READ_MAX);
    end else begin
      want = bit_count_i[mfbr_pkg::LEFT_W-1:0];
    end
  end

  // Pointer arithmetic modulo MEM_BYTES; both operands are already reduced.
  always_comb begin
    ptr_sum  = {1'b0, ptr_q} + {1'b0, red_result};
    ptr_add  = (ptr_sum >= ModW) ? AW'(ptr_sum - ModW) : ptr_sum[AW-1:0];
    ptr_inc  = (ptr_q == LastW) ? '0 : ptr_q + 1'b1;
    fptr_inc = (fptr_q == LastW) ? '0 : fptr_q + 1'b1;
  end

  // Fetch address: base + (pointer XOR 3), both reduced modulo MEM_BYTES.
  always_comb begin
    swz       = fptr_q ^ AW'(3);
    swz_red   = ({1'b0, swz} >= ModW) ? ({1'b0, swz} - ModW) : {1'b0, swz};
    faddr_sum = {1'b0, base_mod_q} + swz_red;
    faddr     = (faddr_sum >= ModW) ? AW'(faddr_sum - ModW) : faddr_sum[AW-1:0];
  end

  // Take as many bits of the current byte as the read still needs.
  always_comb begin
    avail  = 4'd8 - {1'b0, bo_q};
    take   = (left_q < {2'b00, avail}) ? left_q[3:0] : avail;
    drop   = 3'(avail - take);
    field  = (rdata >> drop) & mfbr_pkg::LOW_MASK[take];
    acc_d  = (acc_q << take) | {24'd0, field};
    bo_sum = {1'b0, bo_q} + take;
    left_d = left_q - {2'b00, take};
  end

  assign mem_we = (state_q == S_RED) && red_done && (op_q == mfbr_pkg::REQ_WRITE);

  mfbr_modred #(
    .MOD (MEM_BYTES),
    .AW  (AW)
  ) u_modred (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (accept && (req != mfbr_pkg::REQ_READ)),
    .operand_i (red_operand),
    .done_o    (red_done),
    .result_o  (red_result)
  );

  mfbr_mem #(
    .DEPTH (MEM_BYTES),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (red_result),
    .wdata_i (wdata_q),
    .raddr_i (faddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= mfbr_pkg::REQ_WRITE;
      wdata_q     <= '0;
      base_zero_q <= 1'b1;
      base_mod_q  <= '0;
      ptr_q       <= '0;
      fptr_q      <= '0;
      bo_q        <= '0;
      left_q      <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // In S_PUSH the output register is refilled below instead.
      if (out_valid_q && out_ready_i && (state_q != S_PUSH)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            op_q    <= req;
            wdata_q <= write_data_i;
            unique case (req)
              mfbr_pkg::REQ_START: begin
                base_zero_q <= (address_i == '0);
                ptr_q       <= '0;
                bo_q        <= '0;
                state_q     <= S_RED;
              end
              mfbr_pkg::REQ_SKIP: begin
                bo_q    <= skip_total[2:0];
                state_q <= S_RED;
              end
              mfbr_pkg::REQ_READ: begin
                acc_q   <= '0;
                left_q  <= want;
                fptr_q  <= ptr_q;
                state_q <= base_zero_q ? S_PUSH : S_FETCH;
              end
              default: begin
                state_q <= S_RED;
              end
            endcase
          end
        end
        S_RED: begin
          if (red_done) begin
            if (op_q == mfbr_pkg::REQ_START) begin
              base_mod_q <= red_result;
            end else if (op_q == mfbr_pkg::REQ_SKIP) begin
              ptr_q <= ptr_add;
            end
            state_q <= S_IDLE;
          end
        end
        S_FETCH: begin
          fptr_q  <= fptr_inc;
          state_q <= S_READ;
        end
        S_READ: begin
          // The next byte is requested every cycle; only the first and last bytes of a read can be
          // partly used, so the prefetch never runs ahead of a byte still needed.
          fptr_q <= fptr_inc;
          acc_q  <= acc_d;
          left_q <= left_d;
          bo_q   <= bo_sum[2:0];
          if (bo_sum[3]) begin
            ptr_q <= ptr_inc;
          end
          if (left_d == '0) begin
            state_q <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_q       <= acc_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign read_value_o = out_q;

endmodule

// ===== rtl/mfbr_checker.sv =====
module mfbr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  req_type_i,
  input logic [11:0] address_i,
  input logic [7:0]  write_data_i,
  input logic [15:0] bit_count_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] read_value_o
);

  // A result holds until its transfer completes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(read_value_o)))
    else $error("result dropped or changed while stalled");

  // A waiting request keeps its payload until its transfer completes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_ready_o) |=>
      (in_valid_i && $stable({req_type_i, address_i, write_data_i, bit_count_i})))
    else $error("request dropped or changed while stalled");

  // Only one request is in flight: a transfer closes the request port.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted while another is in flight");

  // Requests other than reads never produce a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (req_type_i != mfbr_pkg::REQ_READ)) |=> !$rose(out_valid_o))
    else $error("result produced by a request that is not a read");

  // A new result only appears while a request is being worked on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared with no request in flight");

endmodule

bind msb_first_bit_reader mfbr_checker u_mfbr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .req_type_i   (req_type_i),
  .address_i    (address_i),
  .write_data_i (write_data_i),
  .bit_count_i  (bit_count_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .read_value_o (read_value_o)
);

// ===== test/tb_msb_first_bit_reader.sv =====
`timescale 1ns / 100ps

module tb_msb_first_bit_reader;

  typedef struct packed {
    mfbr_pkg::req_e kind;
    logic [11:0]    addr;
    logic [7:0]     data;
    logic [15:0]    count;
  } request_t;

  localparam int unsigned REQUEST_TARGET = 1150;
  localparam int unsigned STALL_LIMIT    = 4000;
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int unsigned HOLD_AT        = 3000;
  localparam int unsigned HOLD_LEN       = 400;
  localparam int unsigned CALM_FROM      = 10000;
  localparam int unsigned CALM_TO        = 16000;
  // Two copies of the stream state: one steers stimulus, one predicts results.
  localparam int unsigned PLANNER = 0;
  localparam int unsigned CHECKER = 1;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [1:0]  req_type_i   = '0;
  logic [11:0] address_i    = '0;
  logic [7:0]  write_data_i = '0;
  logic [15:0] bit_count_i  = '0;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic [31:0] read_value_o;

  msb_first_bit_reader DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .address_i    (address_i),
    .write_data_i (write_data_i),
    .bit_count_i  (bit_count_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .read_value_o (read_value_o)
  );

  logic [7:0]  byte_image [2][4096];
  logic [11:0] stream_base [2];
  logic [11:0] byte_ptr [2];
  logic [2:0]  bit_pos [2];
  bit          byte_written [4096];

  request_t    pending_requests [$];
  logic [31:0] value_due [$];

  int unsigned run_cycles;
  int unsigned quiet_cycles;
  int unsigned hold_left;
  int unsigned failures;
  int unsigned results_seen;
  int unsigned kind_seen [4];

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [5:0] clamp_width(input logic [15:0] count);
    if (count == 16'd0) return 6'd1;
    if (count > 16'd32) return 6'd32;
    return count[5:0];
  endfunction

  // Applies one request to the chosen state copy and returns the field a read yields.
  function automatic void stream_step(input int unsigned inst, input request_t r,
                                      output logic has_value, output logic [31:0] value);
    logic [39:0] window;
    logic [39:0] aligned;
    logic [5:0]  width;
    logic [16:0] total;
    logic [11:0] n;
    logic [11:0] a;
    has_value = 1'b0;
    value = '0;
    case (r.kind)
      mfbr_pkg::REQ_WRITE: begin
        byte_image[inst][r.addr] = r.data;
      end
      mfbr_pkg::REQ_START: begin
        stream_base[inst] = r.addr;
        byte_ptr[inst] = '0;
        bit_pos[inst] = '0;
      end
      mfbr_pkg::REQ_SKIP: begin
        total = {1'b0, r.count} + 17'(bit_pos[inst]);
        byte_ptr[inst] = byte_ptr[inst] + 12'(total[16:3]);
        bit_pos[inst] = total[2:0];
      end
      default: begin
        has_value = 1'b1;
        width = clamp_width(r.count);
        if (stream_base[inst] != '0) begin
          window = '0;
          for (int k = 0; k < 5; k++) begin
            n = byte_ptr[inst] + 12'(k);
            a = stream_base[inst] + (n ^ 12'd3);
            window = {window[31:0], byte_image[inst][a]};
          end
          // Bits ahead of the field and bits past its end are shifted out.
          aligned = window << bit_pos[inst];
          value = aligned[39:8] >> (6'd32 - width);
          total = 17'(bit_pos[inst]) + 17'(width);
          byte_ptr[inst] = byte_ptr[inst] + 12'(total[16:3]);
          bit_pos[inst] = total[2:0];
        end
      end
    endcase
  endfunction

  function automatic request_t make_request(input mfbr_pkg::req_e kind,
                                            input logic [11:0] addr,
                                            input logic [7:0] data, input logic [15:0] count);
    request_t r;
    r.kind = kind;
    r.addr = addr;
    r.data = data;
    r.count = count;
    return r;
  endfunction

  function automatic logic [15:0] pick_read_count();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 5) return 16'd0;
    if (roll < 12) return 16'($urandom_range(33, 65535));
    return 16'($urandom_range(1, 32));
  endfunction

  function automatic logic [15:0] pick_skip_count();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return 16'($urandom_range(65535));
    if (roll < 15) return 16'd0;
    return 16'($urandom_range(1, 40));
  endfunction

  // Queues a request. Before a read, every byte it will touch that was never
  // written gets a write of random data, so no stale memory is ever read.
  task automatic queue_request(input request_t r);
    logic        has_value;
    logic [31:0] value;
    logic [5:0]  width;
    int unsigned span;
    logic [11:0] a;
    if (r.kind == mfbr_pkg::REQ_READ && stream_base[PLANNER] != '0) begin
      width = clamp_width(r.count);
      span = ((int'(bit_pos[PLANNER]) + int'(width) - 1) >> 3) + 1;
      for (int k = 0; k < span; k++) begin
        a = stream_base[PLANNER] + ((byte_ptr[PLANNER] + 12'(k)) ^ 12'd3);
        if (!byte_written[a]) begin
          queue_request(make_request(mfbr_pkg::REQ_WRITE, a, 8'($urandom), 16'($urandom)));
        end
      end
    end
    if (r.kind == mfbr_pkg::REQ_WRITE) byte_written[r.addr] = 1'b1;
    stream_step(PLANNER, r, has_value, value);
    pending_requests.push_back(r);
  endtask

  always @(posedge clk_i) begin
    run_cycles <= run_cycles + 1;
  end

  // Request driver.
  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    logic        took;
    logic        has_value;
    logic [31:0] value;
    logic        calm;
    request_t    r;
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      req_type_i   <= '0;
      address_i    <= '0;
      write_data_i <= '0;
      bit_count_i  <= '0;
    end else begin
      took = in_valid_i && in_ready_o;
      if (took) begin
        r = make_request(mfbr_pkg::req_e'(req_type_i), address_i, write_data_i, bit_count_i);
        stream_step(CHECKER, r, has_value, value);
        if (has_value) value_due.push_back(value);
        kind_seen[req_type_i]++;
      end
      if (!in_valid_i || took) begin
        calm = run_cycles >= CALM_FROM && run_cycles < CALM_TO;
        if (pending_requests.size() > 0 && (calm || $urandom_range(99) >= 23)) begin
          r = pending_requests.pop_front();
          in_valid_i   <= 1'b1;
          req_type_i   <= r.kind;
          address_i    <= r.addr;
          write_data_i <= r.data;
          bit_count_i  <= r.count;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result receiver. Once in the run it holds off for a long stretch so that
  // the block backs up and stalls its request channel.
  always @(posedge clk_i or negedge rst_ni) begin : accept_results
    logic calm;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left   <= 0;
    end else begin
      calm = run_cycles >= CALM_FROM && run_cycles < CALM_TO;
      if (run_cycles == HOLD_AT) begin
        hold_left   <= HOLD_LEN;
        out_ready_i <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left   <= hold_left - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= calm || $urandom_range(99) >= 23;
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    logic [31:0] due;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (value_due.size() == 0) begin
        $error("read_value: expected no transfer, got %h", read_value_o);
        failures++;
      end else begin
        due = value_due.pop_front();
        if (read_value_o !== due) begin
          $error("read_value: expected %h, got %h", due, read_value_o);
          failures++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $error("no transfer for %0d cycles, %0d results still due", STALL_LIMIT,
               value_due.size());
        $display("status: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    for (int i = 0; i < 4096; i++) begin
      byte_written[i] = 1'b0;
      for (int j = 0; j < 2; j++) byte_image[j][i] = '0;
    end
    for (int j = 0; j < 2; j++) begin
      stream_base[j] = '0;
      byte_ptr[j] = '0;
      bit_pos[j] = '0;
    end
    run_cycles = 0;
    quiet_cycles = 0;
    failures = 0;
    results_seen = 0;
    for (int k = 0; k < 4; k++) kind_seen[k] = 0;

    // Reads and a skip before any stream base is set.
    queue_request(make_request(mfbr_pkg::REQ_READ, 12'($urandom), 8'($urandom), 16'd0));
    queue_request(make_request(mfbr_pkg::REQ_SKIP, 12'($urandom), 8'($urandom), 16'd13));
    queue_request(make_request(mfbr_pkg::REQ_READ, 12'($urandom), 8'($urandom), 16'hffff));
    queue_request(make_request(mfbr_pkg::REQ_WRITE, 12'hfff, 8'hff, 16'($urandom)));
    queue_request(make_request(mfbr_pkg::REQ_WRITE, 12'h000, 8'h00, 16'($urandom)));
    // A base near the top of memory makes fetch addresses wrap.
    queue_request(make_request(mfbr_pkg::REQ_START, 12'd4092, 8'($urandom), 16'($urandom)));
    queue_request(make_request(mfbr_pkg::REQ_READ, 12'($urandom), 8'($urandom), 16'd32));
    queue_request(make_request(mfbr_pkg::REQ_SKIP, 12'($urandom), 8'($urandom), 16'd3));
    queue_request(make_request(mfbr_pkg::REQ_READ, 12'($urandom), 8'($urandom), 16'd40));
    queue_request(make_request(mfbr_pkg::REQ_READ, 12'($urandom), 8'($urandom), 16'd1));
    queue_request(make_request(mfbr_pkg::REQ_READ, 12'($urandom), 8'($urandom), 16'd4));
    queue_request(make_request(mfbr_pkg::REQ_READ, 12'($urandom), 8'($urandom), 16'd0));
    queue_request(make_request(mfbr_pkg::REQ_SKIP, 12'($urandom), 8'($urandom), 16'd0));
    // The largest skip carries the pointer past the end of memory.
    queue_request(make_request(mfbr_pkg::REQ_SKIP, 12'($urandom), 8'($urandom), 16'hffff));
    queue_request(make_request(mfbr_pkg::REQ_READ, 12'($urandom), 8'($urandom), 16'd8));
    queue_request(make_request(mfbr_pkg::REQ_START, 12'h000, 8'($urandom), 16'($urandom)));
    queue_request(make_request(mfbr_pkg::REQ_READ, 12'($urandom), 8'($urandom), 16'd17));
    queue_request(make_request(mfbr_pkg::REQ_START, 12'hfff, 8'($urandom), 16'($urandom)));
    queue_request(make_request(mfbr_pkg::REQ_READ, 12'($urandom), 8'($urandom), 16'd32));

    // Mostly a start followed by reads and skips; the rest is loose requests.
    while (pending_requests.size() < REQUEST_TARGET) begin
      if ($urandom_range(99) < 75) begin
        queue_request(make_request(mfbr_pkg::REQ_START,
                                   ($urandom_range(9) == 0) ? 12'd0 : 12'($urandom_range(1, 4095)),
                                   8'($urandom), 16'($urandom)));
        repeat ($urandom_range(3, 12)) begin
          if ($urandom_range(99) < 60) begin
            queue_request(make_request(mfbr_pkg::REQ_READ, 12'($urandom), 8'($urandom),
                                       pick_read_count()));
          end else begin
            queue_request(make_request(mfbr_pkg::REQ_SKIP, 12'($urandom), 8'($urandom),
                                       pick_skip_count()));
          end
        end
      end else begin
        queue_request(make_request(mfbr_pkg::req_e'(2'($urandom_range(3))), 12'($urandom),
                                   8'($urandom), 16'($urandom)));
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_requests.size() > 0 || in_valid_i || value_due.size() > 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Sent %0d writes, %0d starts, %0d skips and %0d reads in %0d cycles.",
             kind_seen[mfbr_pkg::REQ_WRITE], kind_seen[mfbr_pkg::REQ_START],
             kind_seen[mfbr_pkg::REQ_SKIP], kind_seen[mfbr_pkg::REQ_READ], run_cycles);
    $display("Checked %0d read results, with wrapped fetches and a long result stall.",
             results_seen);
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
